>>> rtl/ksca_pkg.sv
package ksca_pkg;

  // Table depth used when the top level is not given another one.
  localparam int TABLE_DEPTH_DEF = 256;

  // Field widths of the transaction payloads.
  localparam int KEY_W      = 64;
  localparam int CTX_W      = 2;
  localparam int SCOV_W     = 16;
  localparam int LVL_W      = 17;
  localparam int RIDX_W     = 8;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = 32;
  localparam int COV_W      = 48;
  localparam int WSUM_W     = 64;
  localparam int MCOV_W     = 24;
  localparam int MMETH_W    = 17;
  localparam int USED_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Shared divider operand widths.
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 48;

  // Fixed-point one for the methylation level.
  localparam logic [LVL_W-1:0] LEVEL_ONE = 17'h10000;
  localparam logic [SCOV_W-1:0] MIN_COV_RST = 16'd1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FILTERED = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_EN = 2'd0,
    CFG_CONTEXT   = 2'd1,
    CFG_MIN_COV   = 2'd2
  } cfg_reg_t;

  // One table entry as it is kept in memory.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  cnt;
    logic [COV_W-1:0]  cov;
    logic [WSUM_W-1:0] wsum;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    scan_start;
    logic    scan_step;
    logic    hit_capture;
    logic    new_capture;
    logic    upd;
    logic    rd_issue;
    logic    rd_capture;
    logic    div_start;
    logic    div_capture;
    logic    div_sel;
    logic    out_load;
    status_t out_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic filtered;
    logic idx_empty;
    logic used_zero;
    logic full;
    logic match;
    logic last;
    logic div_done;
  } sts_t;

endpackage

>>> rtl/keyed_site_coverage_aggregator.sv
// Accumulate: the key scan of the table RAM compares one entry per cycle until the key is found
// or every used entry is compared; a found key is then updated, a new key is added and updated,
// and a full table, a filtered site or an empty-index read gives its result without an update.
// Read: two 64-step bit-serial divisions run in turn in one shared divider.
// One transaction is in work at a time; the next is accepted the cycle after the result
// is registered, even while that result still waits to be taken.
// Synchronous reset empties the table, restores the register defaults and drops results.
module keyed_site_coverage_aggregator #(
  parameter int TABLE_DEPTH = ksca_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [ksca_pkg::KEY_W-1:0]      in_cell_key,
  input  logic [ksca_pkg::CTX_W-1:0]      in_site_context,
  input  logic [ksca_pkg::SCOV_W-1:0]     in_site_coverage,
  input  logic [ksca_pkg::LVL_W-1:0]      in_meth_level,
  input  logic [ksca_pkg::RIDX_W-1:0]     in_read_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ksca_pkg::STAT_W-1:0]     out_status,
  output logic [ksca_pkg::RIDX_W-1:0]     out_entry_index,
  output logic [ksca_pkg::KEY_W-1:0]      out_key_out,
  output logic [ksca_pkg::CNT_W-1:0]      out_site_count,
  output logic [ksca_pkg::COV_W-1:0]      out_coverage_sum,
  output logic [ksca_pkg::WSUM_W-1:0]     out_weighted_sum,
  output logic [ksca_pkg::MCOV_W-1:0]     out_mean_coverage_q8,
  output logic [ksca_pkg::MMETH_W-1:0]    out_mean_meth_q16,
  output logic [ksca_pkg::USED_W-1:0]     out_entries_used,
  input  logic                            cfg_we,
  input  logic [ksca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ksca_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ksca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  ksca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, arithmetic and result register.
  ksca_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_req_type          (in_req_type),
    .in_cell_key          (in_cell_key),
    .in_site_context      (in_site_context),
    .in_site_coverage     (in_site_coverage),
    .in_meth_level        (in_meth_level),
    .in_read_index        (in_read_index),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_status           (out_status),
    .out_entry_index      (out_entry_index),
    .out_key_out          (out_key_out),
    .out_site_count       (out_site_count),
    .out_coverage_sum     (out_coverage_sum),
    .out_weighted_sum     (out_weighted_sum),
    .out_mean_coverage_q8 (out_mean_coverage_q8),
    .out_mean_meth_q16    (out_mean_meth_q16),
    .out_entries_used     (out_entries_used)
  );

endmodule

>>> rtl/ksca_div.sv
module ksca_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ksca_pkg::DIV_N_W-1:0] dividend,
  input  logic [ksca_pkg::DIV_D_W-1:0] divisor,
  output logic                         done,
  output logic [ksca_pkg::DIV_N_W-1:0] quotient
);
  import ksca_pkg::*;

  localparam int CW = $clog2(DIV_N_W + 1);

  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W-1:0] dsr_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_r, quo_r[DIV_N_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo_r <= {quo_r[DIV_N_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/ksca_dp.sv
module ksca_dp #(
  parameter int TABLE_DEPTH = ksca_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ksca_pkg::cmd_t                  cmd,
  output ksca_pkg::sts_t                  sts,
  input  logic                            in_req_type,
  input  logic [ksca_pkg::KEY_W-1:0]      in_cell_key,
  input  logic [ksca_pkg::CTX_W-1:0]      in_site_context,
  input  logic [ksca_pkg::SCOV_W-1:0]     in_site_coverage,
  input  logic [ksca_pkg::LVL_W-1:0]      in_meth_level,
  input  logic [ksca_pkg::RIDX_W-1:0]     in_read_index,
  input  logic                            cfg_we,
  input  logic [ksca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ksca_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [ksca_pkg::STAT_W-1:0]     out_status,
  output logic [ksca_pkg::RIDX_W-1:0]     out_entry_index,
  output logic [ksca_pkg::KEY_W-1:0]      out_key_out,
  output logic [ksca_pkg::CNT_W-1:0]      out_site_count,
  output logic [ksca_pkg::COV_W-1:0]      out_coverage_sum,
  output logic [ksca_pkg::WSUM_W-1:0]     out_weighted_sum,
  output logic [ksca_pkg::MCOV_W-1:0]     out_mean_coverage_q8,
  output logic [ksca_pkg::MMETH_W-1:0]    out_mean_meth_q16,
  output logic [ksca_pkg::USED_W-1:0]     out_entries_used
);
  import ksca_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int UW    = $clog2(TABLE_DEPTH + 1);

  // Configuration registers.
  logic              filt_en_r;
  logic [CTX_W-1:0]  ctx_sel_r;
  logic [SCOV_W-1:0] min_cov_r;

  // Captured request.
  logic              req_r;
  logic [KEY_W-1:0]  key_r;
  logic [CTX_W-1:0]  ctx_r;
  logic [SCOV_W-1:0] cov_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [RIDX_W-1:0] ridx_r;

  // Table and scan state.
  entry_t            mem [TABLE_DEPTH];
  entry_t            rdata_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_re;
  logic [UW-1:0]     used_r;
  logic [UW-1:0]     ptr_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_ptr_r;
  logic [IDX_W-1:0]  slot_r;
  entry_t            acc_r;
  entry_t            acc_nxt;

  // Arithmetic.
  logic [LVL_W-1:0]         lvl_clamp;
  logic [SCOV_W+LVL_W-1:0]  prod_r;
  logic [COV_W:0]           cov_sum;
  logic [WSUM_W:0]          wsum_sum;
  logic [DIV_N_W-1:0]       div_n;
  logic [DIV_D_W-1:0]       div_d;
  logic                     div_done;
  logic [DIV_N_W-1:0]       div_q;
  logic [MCOV_W-1:0]        mcov_r;
  logic [MMETH_W-1:0]       mmeth_r;

  // Output registers.
  logic [STAT_W-1:0]  o_status_r;
  logic [RIDX_W-1:0]  o_index_r;
  logic [KEY_W-1:0]   o_key_r;
  logic [CNT_W-1:0]   o_cnt_r;
  logic [COV_W-1:0]   o_cov_r;
  logic [WSUM_W-1:0]  o_wsum_r;
  logic [MCOV_W-1:0]  o_mcov_r;
  logic [MMETH_W-1:0] o_mmeth_r;
  logic [USED_W-1:0]  o_used_r;
  logic [31:0]        slot32;
  logic [31:0]        used32;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_en_r <= 1'b0;
      ctx_sel_r <= '0;
      min_cov_r <= MIN_COV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_EN: filt_en_r <= cfg_data[0];
        CFG_CONTEXT:   ctx_sel_r <= cfg_data[CTX_W-1:0];
        CFG_MIN_COV:   min_cov_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Request capture at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      key_r  <= in_cell_key;
      ctx_r  <= in_site_context;
      cov_r  <= in_site_coverage;
      lvl_r  <= in_meth_level;
      ridx_r <= in_read_index;
    end
  end

  // Coverage times clamped level, registered ahead of the update.
  assign lvl_clamp = (lvl_r > LEVEL_ONE) ? LEVEL_ONE : lvl_r;
  always_ff @(posedge clk) begin
    prod_r <= cov_r * lvl_clamp;
  end

  // Saturating update of the selected entry.
  assign cov_sum  = {1'b0, acc_r.cov} + (COV_W+1)'(cov_r);
  assign wsum_sum = {1'b0, acc_r.wsum} + (WSUM_W+1)'(prod_r);
  always_comb begin
    acc_nxt      = acc_r;
    acc_nxt.cnt  = (&acc_r.cnt) ? acc_r.cnt : acc_r.cnt + 1'b1;
    acc_nxt.cov  = cov_sum[COV_W] ? {COV_W{1'b1}} : cov_sum[COV_W-1:0];
    acc_nxt.wsum = wsum_sum[WSUM_W] ? {WSUM_W{1'b1}} : wsum_sum[WSUM_W-1:0];
  end

  // Memory read address selection.
  always_comb begin
    mem_re  = cmd.rd_issue | cmd.scan_start | cmd.scan_step;
    rd_addr = '0;
    if (cmd.rd_issue) begin
      rd_addr = IDX_W'(ridx_r);
    end else if (cmd.scan_step) begin
      rd_addr = ptr_r[IDX_W-1:0];
    end
  end

  // Entry memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      mem[slot_r] <= acc_nxt;
    end
    if (mem_re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Fill count and scan pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      cmp_vld_r <= 1'b0;
      ptr_r     <= '0;
    end else begin
      if (cmd.new_capture) begin
        used_r <= used_r + 1'b1;
      end
      if (cmd.scan_start) begin
        ptr_r     <= UW'(1);
        cmp_vld_r <= 1'b1;
      end else if (cmd.scan_step) begin
        ptr_r     <= ptr_r + 1'b1;
        cmp_vld_r <= ptr_r < used_r;
      end else begin
        cmp_vld_r <= 1'b0;
      end
    end
  end

  // Address of the entry now in the read register.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cmp_ptr_r <= '0;
    end else if (cmd.scan_step) begin
      cmp_ptr_r <= ptr_r[IDX_W-1:0];
    end
  end

  // Working copy of the entry and its slot.
  always_ff @(posedge clk) begin
    if (cmd.hit_capture) begin
      acc_r  <= rdata_r;
      slot_r <= cmp_ptr_r;
    end else if (cmd.rd_capture) begin
      acc_r  <= rdata_r;
      slot_r <= IDX_W'(ridx_r);
    end else if (cmd.new_capture) begin
      acc_r  <= '{key: key_r, cnt: '0, cov: '0, wsum: '0};
      slot_r <= used_r[IDX_W-1:0];
    end else if (cmd.upd) begin
      acc_r  <= acc_nxt;
    end
  end

  // Shared divider for both means.
  assign div_n = cmd.div_sel ? acc_r.wsum : DIV_N_W'({acc_r.cov, 8'b0});
  assign div_d = cmd.div_sel ? acc_r.cov : DIV_D_W'(acc_r.cnt);

  ksca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // Means with zero-divisor handling and saturation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mcov_r  <= '0;
      mmeth_r <= '0;
    end else if (cmd.div_capture) begin
      if (!cmd.div_sel) begin
        if (acc_r.cnt == '0) begin
          mcov_r <= '0;
        end else if (|div_q[DIV_N_W-1:MCOV_W]) begin
          mcov_r <= {MCOV_W{1'b1}};
        end else begin
          mcov_r <= div_q[MCOV_W-1:0];
        end
      end else begin
        if (acc_r.cov == '0) begin
          mmeth_r <= '0;
        end else if (div_q > DIV_N_W'(LEVEL_ONE)) begin
          mmeth_r <= LEVEL_ONE;
        end else begin
          mmeth_r <= div_q[MMETH_W-1:0];
        end
      end
    end
  end

  // Result register.
  assign slot32 = 32'(slot_r);
  assign used32 = 32'(used_r);
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status_r <= cmd.out_code;
      o_used_r   <= used32[USED_W-1:0];
      o_index_r  <= '0;
      o_key_r    <= '0;
      o_cnt_r    <= '0;
      o_cov_r    <= '0;
      o_wsum_r   <= '0;
      o_mcov_r   <= '0;
      o_mmeth_r  <= '0;
      case (cmd.out_code)
        ST_OK: begin
          o_index_r <= slot32[RIDX_W-1:0];
          o_key_r   <= acc_r.key;
          o_cnt_r   <= acc_r.cnt;
          o_cov_r   <= acc_r.cov;
          o_wsum_r  <= acc_r.wsum;
          o_mcov_r  <= mcov_r;
          o_mmeth_r <= mmeth_r;
        end
        ST_EMPTY: begin
          o_index_r <= ridx_r;
        end
        default: ;
      endcase
    end
  end

  // Status to the controller.
  assign sts.is_read   = req_r;
  assign sts.filtered  = (filt_en_r && (ctx_r != ctx_sel_r)) || (cov_r < min_cov_r);
  assign sts.idx_empty = 32'(ridx_r) >= used32;
  assign sts.used_zero = used_r == '0;
  assign sts.full      = used32 == 32'(TABLE_DEPTH);
  assign sts.match     = cmp_vld_r && (rdata_r.key == key_r);
  assign sts.last      = cmp_vld_r && ((slot32 & 32'd0) + 32'(cmp_ptr_r) + 32'd1 == used32);
  assign sts.div_done  = div_done;

  assign out_status           = o_status_r;
  assign out_entry_index      = o_index_r;
  assign out_key_out          = o_key_r;
  assign out_site_count       = o_cnt_r;
  assign out_coverage_sum     = o_cov_r;
  assign out_weighted_sum     = o_wsum_r;
  assign out_mean_coverage_q8 = o_mcov_r;
  assign out_mean_meth_q16    = o_mmeth_r;
  assign out_entries_used     = o_used_r;

endmodule

>>> rtl/ksca_ctrl.sv
module ksca_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ksca_pkg::sts_t sts,
  output ksca_pkg::cmd_t cmd
);
  import ksca_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_MISS, S_UPD, S_RDW,
    S_D1S, S_D1, S_D2S, S_D2, S_FIN
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;
  logic    out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    cmd           = '0;
    cmd.out_code  = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_read) begin
          if (sts.idx_empty) begin
            code_nxt  = ST_EMPTY;
            state_nxt = S_FIN;
          end else begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_RDW;
          end
        end else if (sts.filtered) begin
          code_nxt  = ST_FILTERED;
          state_nxt = S_FIN;
        end else if (sts.used_zero) begin
          state_nxt = S_MISS;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.hit_capture = 1'b1;
          state_nxt       = S_UPD;
        end else if (sts.last) begin
          state_nxt = S_MISS;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MISS: begin
        if (sts.full) begin
          code_nxt  = ST_FULL;
          state_nxt = S_FIN;
        end else begin
          cmd.new_capture = 1'b1;
          state_nxt       = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        code_nxt  = ST_OK;
        state_nxt = S_FIN;
      end
      S_RDW: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_D1S;
      end
      S_D1S: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_D1;
      end
      S_D1: begin
        if (sts.div_done) begin
          cmd.div_capture = 1'b1;
          state_nxt       = S_D2S;
        end
      end
      S_D2S: begin
        cmd.div_sel   = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_D2;
      end
      S_D2: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          cmd.div_capture = 1'b1;
          code_nxt        = ST_OK;
          state_nxt       = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/ksca_chk.sv
module ksca_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ksca_pkg::STAT_W-1:0] out_status,
  input logic [ksca_pkg::RIDX_W-1:0] out_entry_index,
  input logic [ksca_pkg::CNT_W-1:0]  out_site_count
);
  import ksca_pkg::*;

  // Reset drops any pending result.
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its status.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  // Input is not taken while a transaction is in work right after acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  // A filtered site reports no entry.
  a_filt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FILTERED) |-> out_entry_index == '0 && out_site_count == '0)
    else $error("filtered result carries entry data");

  // A counted or read entry holds at least one site.
  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> out_site_count != '0)
    else $error("entry result with zero site count");

endmodule

bind keyed_site_coverage_aggregator ksca_chk u_ksca_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_entry_index (out_entry_index),
  .out_site_count  (out_site_count)
);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import ksca_pkg::*;

  localparam int DEPTH = 256;
  localparam int RANDOM_ITEMS = 1300;
  localparam int NUM_PHASES = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic REQ_SITE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // One input transaction.
  typedef struct {
    logic              req;
    logic [KEY_W-1:0]  key;
    logic [CTX_W-1:0]  ctx;
    logic [SCOV_W-1:0] cov;
    logic [LVL_W-1:0]  lvl;
    logic [RIDX_W-1:0] ridx;
  } site_req_t;

  // One result transaction.
  typedef struct {
    status_t            status;
    logic [RIDX_W-1:0]  idx;
    logic [KEY_W-1:0]   key;
    logic [CNT_W-1:0]   cnt;
    logic [COV_W-1:0]   cov;
    logic [WSUM_W-1:0]  wsum;
    logic [MCOV_W-1:0]  mcov;
    logic [MMETH_W-1:0] mmeth;
    logic [USED_W-1:0]  used;
  } agg_result_t;

  // Directed row: a typed result is given only where it is obvious.
  typedef struct {
    site_req_t   item;
    bit          typed;
    agg_result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [KEY_W-1:0] in_cell_key = '0;
  logic [CTX_W-1:0] in_site_context = '0;
  logic [SCOV_W-1:0] in_site_coverage = '0;
  logic [LVL_W-1:0] in_meth_level = '0;
  logic [RIDX_W-1:0] in_read_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [RIDX_W-1:0] out_entry_index;
  logic [KEY_W-1:0] out_key_out;
  logic [CNT_W-1:0] out_site_count;
  logic [COV_W-1:0] out_coverage_sum;
  logic [WSUM_W-1:0] out_weighted_sum;
  logic [MCOV_W-1:0] out_mean_coverage_q8;
  logic [MMETH_W-1:0] out_mean_meth_q16;
  logic [USED_W-1:0] out_entries_used;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  keyed_site_coverage_aggregator u_dut (.*);

  always #6 clk = ~clk;

  // Predictor state: the aggregation table and the register copies.
  logic [KEY_W-1:0]  tbl_key [DEPTH];
  logic [CNT_W-1:0]  tbl_cnt [DEPTH];
  logic [COV_W-1:0]  tbl_cov [DEPTH];
  logic [WSUM_W-1:0] tbl_wsum [DEPTH];
  int unsigned tbl_used = 0;
  logic filt_en = 1'b0;
  logic [CTX_W-1:0] ctx_sel = '0;
  logic [SCOV_W-1:0] min_cov = MIN_COV_RST;

  agg_result_t pending_results[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  function automatic agg_result_t zero_result(status_t st, logic [RIDX_W-1:0] idx);
    agg_result_t r;
    r = '{status: st, idx: idx, key: '0, cnt: '0, cov: '0, wsum: '0,
          mcov: '0, mmeth: '0, used: tbl_used[USED_W-1:0]};
    return r;
  endfunction

  // Computes the result of one transaction and updates the table copy.
  function automatic agg_result_t aggregate_site(site_req_t it);
    agg_result_t r;
    logic [63:0] lvl, prod, sum, q;
    int slot;
    if (it.req == REQ_READ) begin
      if (it.ridx >= tbl_used) return zero_result(ST_EMPTY, it.ridx);
      r = zero_result(ST_OK, it.ridx);
      r.key = tbl_key[it.ridx];
      r.cnt = tbl_cnt[it.ridx];
      r.cov = tbl_cov[it.ridx];
      r.wsum = tbl_wsum[it.ridx];
      if (r.cnt != 0) begin
        q = {8'd0, r.cov, 8'd0} / r.cnt;
        r.mcov = (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[MCOV_W-1:0];
      end
      if (r.cov != 0) begin
        q = r.wsum / r.cov;
        r.mmeth = (q > LEVEL_ONE) ? LEVEL_ONE : q[MMETH_W-1:0];
      end
      return r;
    end
    if ((filt_en && it.ctx != ctx_sel) || it.cov < min_cov)
      return zero_result(ST_FILTERED, '0);
    slot = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_key[i] == it.key) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) begin
      if (tbl_used >= DEPTH) return zero_result(ST_FULL, '0);
      slot = tbl_used;
      tbl_key[slot] = it.key;
      tbl_cnt[slot] = '0;
      tbl_cov[slot] = '0;
      tbl_wsum[slot] = '0;
      tbl_used++;
    end
    lvl = (it.lvl > LEVEL_ONE) ? 64'(LEVEL_ONE) : 64'(it.lvl);
    if (tbl_cnt[slot] != '1) tbl_cnt[slot] = tbl_cnt[slot] + 1;
    sum = 64'(tbl_cov[slot]) + 64'(it.cov);
    tbl_cov[slot] = (sum > 64'hFFFF_FFFF_FFFF) ? '1 : sum[COV_W-1:0];
    prod = 64'(it.cov) * lvl;
    sum = tbl_wsum[slot] + prod;
    tbl_wsum[slot] = (sum < tbl_wsum[slot]) ? '1 : sum;
    r = zero_result(ST_OK, slot[RIDX_W-1:0]);
    r.key = tbl_key[slot];
    r.cnt = tbl_cnt[slot];
    r.cov = tbl_cov[slot];
    r.wsum = tbl_wsum[slot];
    return r;
  endfunction

  // Register write, mirrored in the predictor.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FILTER_EN: filt_en = val[0];
      CFG_CONTEXT:   ctx_sel = val[CTX_W-1:0];
      CFG_MIN_COV:   min_cov = val;
      default: ;
    endcase
  endtask

  // Offers one transaction and waits for the handshake.
  task automatic offer_site(site_req_t it, bit typed, agg_result_t typed_res);
    agg_result_t r;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req;
    in_cell_key <= it.key;
    in_site_context <= it.ctx;
    in_site_coverage <= it.cov;
    in_meth_level <= it.lvl;
    in_read_index <= it.ridx;
    do @(posedge clk); while (!in_ready);
    r = aggregate_site(it);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic site_req_t random_site();
    site_req_t it;
    int pick;
    it.req = ($urandom_range(99) < 15) ? REQ_READ : REQ_SITE;
    it.ridx = ($urandom_range(99) < 70 && tbl_used > 0) ?
              RIDX_W'($urandom_range(tbl_used - 1)) : RIDX_W'($urandom_range(255));
    if (tbl_used > 0 && $urandom_range(99) < 55)
      it.key = tbl_key[$urandom_range(tbl_used - 1)];
    else
      it.key = {$urandom, $urandom};
    it.ctx = CTX_W'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 8) it.cov = '0;
    else if (pick < 16) it.cov = '1;
    else if (pick < 60) it.cov = SCOV_W'($urandom_range(2000));
    else it.cov = SCOV_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 6) it.lvl = LEVEL_ONE;
    else if (pick < 12) it.lvl = LVL_W'($urandom_range(131071, 65537));
    else it.lvl = LVL_W'($urandom_range(65536));
    return it;
  endfunction

  // Receiver: random stalls plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    agg_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status || out_entry_index !== e.idx || out_key_out !== e.key ||
            out_site_count !== e.cnt || out_coverage_sum !== e.cov ||
            out_weighted_sum !== e.wsum || out_mean_coverage_q8 !== e.mcov ||
            out_mean_meth_q16 !== e.mmeth || out_entries_used !== e.used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d idx=%0d key=%h cnt=%0d cov=%0d ws=%0d mc=%0d mm=%0d u=%0d\n  act st=%0d idx=%0d key=%h cnt=%0d cov=%0d ws=%0d mc=%0d mm=%0d u=%0d",
              e.status, e.idx, e.key, e.cnt, e.cov, e.wsum, e.mcov, e.mmeth, e.used,
              out_status, out_entry_index, out_key_out, out_site_count, out_coverage_sum,
              out_weighted_sum, out_mean_coverage_q8, out_mean_meth_q16, out_entries_used);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #(12 * 3_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    directed_row_t rows[$];
    agg_result_t nores;
    int ends;
    logic [15:0] min_vals [NUM_PHASES] = '{16'd1, 16'd100, 16'd0, 16'hFFFF, 16'd0};
    logic        fen_vals [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    logic [1:0]  ctx_vals [NUM_PHASES] = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd0};
    int          idle_vals [NUM_PHASES] = '{0, 79, 0, 36, 0};
    int          stall_vals [NUM_PHASES] = '{0, 0, 79, 36, 0};

    nores = zero_result(ST_OK, '0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, filtering, extremes and level clamping.
    rows.push_back('{'{REQ_READ, '0, '0, '0, '0, 8'd0}, 1,
                     '{ST_EMPTY, 8'd0, '0, '0, '0, '0, '0, '0, 9'd0}});
    rows.push_back('{'{REQ_SITE, 64'h1, 2'd1, 16'd0, 17'd100, '0}, 1,
                     '{ST_FILTERED, 8'd0, '0, '0, '0, '0, '0, '0, 9'd0}});
    rows.push_back('{'{REQ_SITE, '0, 2'd0, 16'hFFFF, LEVEL_ONE, '0}, 0, nores});
    rows.push_back('{'{REQ_SITE, '1, 2'd3, 16'hFFFF, 17'h1FFFF, '0}, 0, nores});
    rows.push_back('{'{REQ_SITE, '1, 2'd2, 16'd1, 17'd0, '0}, 0, nores});
    rows.push_back('{'{REQ_SITE, 64'hA5A5_5A5A_0F0F_F0F0, 2'd1, 16'd1, 17'd32768, '0},
                     0, nores});
    rows.push_back('{'{REQ_READ, '0, '0, '0, '0, 8'd0}, 0, nores});
    rows.push_back('{'{REQ_READ, '1, '1, '1, '1, 8'd1}, 0, nores});
    rows.push_back('{'{REQ_READ, '0, '0, '0, '0, 8'd2}, 0, nores});
    rows.push_back('{'{REQ_READ, '0, '0, '0, '0, 8'd255}, 1,
                     '{ST_EMPTY, 8'd255, '0, '0, '0, '0, '0, '0, 9'd3}});
    foreach (rows[i]) offer_site(rows[i].item, rows[i].typed, rows[i].res);
    wait_drained();

    // Filter checks, with a write to the spare index that must be ignored.
    write_reg(CFG_FILTER_EN, 16'd1);
    write_reg(CFG_CONTEXT, 16'd2);
    write_reg(CFG_SPARE, 16'hFFFF);
    offer_site('{REQ_SITE, 64'h5, 2'd1, 16'd10, 17'd10, '0}, 1,
               '{ST_FILTERED, 8'd0, '0, '0, '0, '0, '0, '0, 9'd3});
    offer_site('{REQ_SITE, 64'h5, 2'd2, 16'd10, 17'd10, '0}, 0, nores);
    wait_drained();

    // Random phases with different settings, idling and receiver stalls.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_FILTER_EN, 16'(fen_vals[p]));
      write_reg(CFG_CONTEXT, 16'(ctx_vals[p]));
      write_reg(CFG_MIN_COV, min_vals[p]);
      idle_pct = idle_vals[p];
      stall_pct = stall_vals[p];
      if (p == 4) hold_cycles = 2000;
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++)
        offer_site(random_site(), 0, nores);
      wait_drained();
    end

    ends = 0;
    while (pending_results.size() != 0 && ends < 100000) begin
      @(posedge clk);
      ends++;
    end
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
